[rtl/bid_pkg.sv]
// Shared types, command codes and defaults for the bounded indexed deque.
`default_nettype none
package bid_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int DATA_W_DEF = 32;

  localparam int CMD_W  = 4;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_READ       = 4'd4;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_REVERSE    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DEC_ALL    = 4'd8;
  localparam logic [CMD_W-1:0] CMD_INC_ALL    = 4'd9;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd10;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  localparam logic [VAL_W-1:0] VAL_FAIL = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CAPT,
    ST_RD,
    ST_WR,
    ST_WR2,
    ST_PUT
  } state_t;

endpackage
`default_nettype wire

[rtl/bid_if.sv]
// Request and result channel interfaces of the deque.
`default_nettype none
interface bid_in_if
  import bid_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [POS_W-1:0]         position;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface bid_out_if
  import bid_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  result_value;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         count;

  modport source (output valid, result_value, status, count, input ready);
  modport sink   (input valid, result_value, status, count, output ready);
endinterface
`default_nettype wire

[rtl/bounded_indexed_deque.sv]
// Bounded deque with indexed access: sequencer driving the word store.
// Read fetches the word; pop and remove fetch it, then move each later word down;
// push front and insert move each word from the position up, then put the new word;
// reverse swaps pairs from both ends inward; increment and decrement update each
// word held; clear, push back, failures and unused codes move no words. One request
// at a time; every move, swap and update goes through the single store write port.
// Reset clears the count and control state; stored words are not cleared.
`default_nettype none
module bounded_indexed_deque
  import bid_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_W_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bid_in_if.sink     in_ch,
  bid_out_if.source  out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  state_t                 state_r, state_nxt;
  logic [CMD_W-1:0]       op_r, op_nxt;
  logic [CW-1:0]          i_r, i_nxt;
  logic [CW-1:0]          j_r, j_nxt;
  logic [CW-1:0]          lim_r, lim_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0]  wval_r, wval_nxt;
  logic [VAL_W-1:0]       res_r, res_nxt;
  logic                   ov_r, ov_nxt;
  logic [VAL_W-1:0]       oval_r, oval_nxt;
  logic [STAT_W-1:0]      ostat_r, ostat_nxt;
  logic [CNT_W-1:0]       ocnt_r, ocnt_nxt;

  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_ra, mem_rb;
  logic [DATA_WIDTH-1:0]  mem_wdata, rd_a, rd_b;

  logic [CW-1:0]          i_m1, i_p1;
  logic [CW:0]            i_p1w, i_p2w, cnt_w, j_w, lim_p1w;
  logic [PW-1:0]          pos_e, cnt_e;
  logic                   accept, is_full;
  logic [VAL_W-1:0]       rd_out;

  assign i_m1    = i_r - CW'(1);
  assign i_p1    = i_r + CW'(1);
  assign i_p1w   = {1'b0, i_r} + (CW+1)'(1);
  assign i_p2w   = {1'b0, i_r} + (CW+1)'(2);
  assign cnt_w   = {1'b0, cnt_r};
  assign j_w     = {1'b0, j_r};
  assign lim_p1w = {1'b0, lim_r} + (CW+1)'(1);
  assign pos_e   = PW'(in_ch.position);
  assign cnt_e   = PW'(cnt_r);
  assign is_full = (cnt_w == (CW+1)'(DEPTH));
  assign rd_out  = VAL_W'(signed'(rd_a));

  assign in_ch.ready = (state_r == ST_IDLE) && !ov_r;
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = ov_r;
  assign out_ch.result_value = oval_r;
  assign out_ch.status       = ostat_r;
  assign out_ch.count        = ocnt_r;

  bid_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_ra),
    .raddr_b (mem_rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    lim_r   <= lim_nxt;
    wval_r  <= wval_nxt;
    res_r   <= res_nxt;
    oval_r  <= oval_nxt;
    ostat_r <= ostat_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  always_comb begin
    logic             fin;
    logic [VAL_W-1:0] fin_val;
    logic [STAT_W-1:0] fin_stat;
    fin       = 1'b0;
    fin_val   = '0;
    fin_stat  = STAT_OK;
    state_nxt = state_r;
    op_nxt    = op_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    lim_nxt   = lim_r;
    cnt_nxt   = cnt_r;
    wval_nxt  = wval_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r && !out_ch.ready;
    oval_nxt  = oval_r;
    ostat_nxt = ostat_r;
    ocnt_nxt  = ocnt_r;
    mem_we    = 1'b0;
    mem_waddr = i_r[AW-1:0];
    mem_wdata = rd_a;
    mem_re    = 1'b0;
    mem_ra    = i_r[AW-1:0];
    mem_rb    = j_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_ch.cmd;
          wval_nxt = DATA_WIDTH'(in_ch.value);
          res_nxt  = '0;
          case (in_ch.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
              if (in_ch.cmd == CMD_INSERT && pos_e > cnt_e) begin
                fin = 1'b1; fin_val = VAL_FAIL; fin_stat = STAT_RANGE;
              end else if (is_full) begin
                fin = 1'b1; fin_val = VAL_FAIL; fin_stat = STAT_FULL;
              end else begin
                i_nxt = cnt_r;
                if (in_ch.cmd == CMD_PUSH_FRONT) begin
                  lim_nxt = '0;
                end else if (in_ch.cmd == CMD_PUSH_BACK) begin
                  lim_nxt = cnt_r;
                end else begin
                  lim_nxt = CW'(in_ch.position);
                end
                state_nxt = (cnt_r > lim_nxt) ? ST_RD : ST_PUT;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (cnt_r == '0) begin
                fin = 1'b1; fin_val = VAL_FAIL; fin_stat = STAT_RANGE;
              end else begin
                i_nxt     = (in_ch.cmd == CMD_POP_FRONT) ? '0 : cnt_r - CW'(1);
                state_nxt = ST_FETCH;
              end
            end
            CMD_READ, CMD_REMOVE: begin
              if (pos_e >= cnt_e) begin
                fin = 1'b1; fin_val = VAL_FAIL; fin_stat = STAT_RANGE;
              end else begin
                i_nxt     = CW'(in_ch.position);
                state_nxt = ST_FETCH;
              end
            end
            CMD_REVERSE: begin
              i_nxt = '0;
              j_nxt = cnt_r - CW'(1);
              if (cnt_w >= (CW+1)'(2)) begin
                state_nxt = ST_RD;
              end else begin
                fin = 1'b1;
              end
            end
            CMD_DEC_ALL, CMD_INC_ALL: begin
              i_nxt = '0;
              if (cnt_r != '0) begin
                state_nxt = ST_RD;
              end else begin
                fin = 1'b1;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
              fin     = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      ST_FETCH: begin
        mem_re    = 1'b1;
        state_nxt = ST_CAPT;
      end

      ST_CAPT: begin
        if (op_r != CMD_REMOVE) begin
          res_nxt = rd_out;
        end
        if (op_r == CMD_READ) begin
          fin     = 1'b1;
          fin_val = rd_out;
        end else if (i_p1w < cnt_w) begin
          state_nxt = ST_RD;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
          fin     = 1'b1;
          fin_val = res_nxt;
        end
      end

      ST_RD: begin
        mem_re = 1'b1;
        case (op_r)
          CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: mem_ra = i_m1[AW-1:0];
          CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE:   mem_ra = i_p1[AW-1:0];
          default:                                   mem_ra = i_r[AW-1:0];
        endcase
        state_nxt = ST_WR;
      end

      ST_WR: begin
        mem_we = 1'b1;
        case (op_r)
          CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
            // move one word up, towards the back
            i_nxt     = i_m1;
            state_nxt = ({1'b0, i_r} > lim_p1w) ? ST_RD : ST_PUT;
          end
          CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE: begin
            i_nxt = i_p1;
            if (i_p2w < cnt_w) begin
              state_nxt = ST_RD;
            end else begin
              cnt_nxt = cnt_r - CW'(1);
              fin     = 1'b1;
              fin_val = res_r;
            end
          end
          CMD_REVERSE: begin
            mem_wdata = rd_b;
            state_nxt = ST_WR2;
          end
          default: begin
            mem_wdata = (op_r == CMD_DEC_ALL) ? rd_a - DATA_WIDTH'(1)
                                              : rd_a + DATA_WIDTH'(1);
            i_nxt = i_p1;
            if (i_p1w < cnt_w) begin
              state_nxt = ST_RD;
            end else begin
              fin = 1'b1;
            end
          end
        endcase
      end

      ST_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[AW-1:0];
        i_nxt     = i_p1;
        j_nxt     = j_r - CW'(1);
        if (i_p2w < j_w) begin
          state_nxt = ST_RD;
        end else begin
          fin = 1'b1;
        end
      end

      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = lim_r[AW-1:0];
        mem_wdata = wval_r;
        cnt_nxt   = cnt_r + CW'(1);
        fin       = 1'b1;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = ST_IDLE;
      ov_nxt    = 1'b1;
      oval_nxt  = fin_val;
      ostat_nxt = fin_stat;
      ocnt_nxt  = CNT_W'(cnt_nxt);
    end
  end

  a_out_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> state_r == ST_IDLE)
    else $error("result pending while sequencer busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_w <= (CW+1)'(DEPTH))
    else $error("word count beyond depth");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE) || ov_r)
    else $error("request accepted without work or result");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_WR || state_r == ST_WR2 || state_r == ST_PUT))
    else $error("store written outside a write step");

endmodule
`default_nettype wire

[rtl/bid_mem.sv]
// Word store: one write port, two registered read ports.
`default_nettype none
module bid_mem
  import bid_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_W_DEF,
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr_a,
  input  wire logic [AW-1:0]         raddr_b,
  output logic      [DATA_WIDTH-1:0] rdata_a,
  output logic      [DATA_WIDTH-1:0] rdata_b
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire
